// ===== src/vector3_normalizer_defines.svh =====
// Assertion macros used by the normalizer RTL.
`ifndef VECTOR3_NORMALIZER_DEFINES_SVH
`define VECTOR3_NORMALIZER_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define V3N_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Assert that a condition holds in the cycle after a trigger.
`define V3N_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ===== src/v3n_pkg.sv =====
`default_nettype none
package v3n_pkg;
   typedef struct packed {
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               ok;
   } rsp_type;

   // Register byte addresses.
   localparam logic [1:0] ADDR_EPSILON_LEN = 2'd0;

   // Stage counts of the iterative units.
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 63;
endpackage
`default_nettype wire

// ===== src/v3n_sqrt.sv =====
`default_nettype none
// Pipelined restoring square root of a 64-bit value, one result bit per stage.
// Sideband data (magnitudes, signs) travels along with each item.
module v3n_sqrt #(
   parameter int SideW = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire logic [63:0]      in_sum,
   input  wire logic [SideW-1:0] in_side,
   output logic                  out_valid,
   output logic [31:0]           out_root,
   output logic [SideW-1:0]      out_side
);
   import v3n_pkg::*;

   logic [SQRT_STEPS:1]       vld_ff;
   logic [63:0]               rem_ff  [1:SQRT_STEPS];
   logic [31:0]               root_ff [1:SQRT_STEPS];
   logic [63:0]               src_ff  [1:SQRT_STEPS];
   logic [SideW-1:0]          side_ff [1:SQRT_STEPS];

   // Each stage brings down two radicand bits and decides one root bit.
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
      logic             cur_vld;
      logic [63:0]      cur_rem;
      logic [31:0]      cur_root;
      logic [63:0]      cur_src;
      logic [SideW-1:0] cur_side;
      logic [65:0]      rem_in;
      logic [65:0]      trial;

      // The first stage starts from the incoming sum with an empty root.
      if (i == 0) begin : g_first
         assign cur_vld  = in_valid;
         assign cur_rem  = '0;
         assign cur_root = '0;
         assign cur_src  = in_sum;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_vld  = vld_ff[i];
         assign cur_rem  = rem_ff[i];
         assign cur_root = root_ff[i];
         assign cur_src  = src_ff[i];
         assign cur_side = side_ff[i];
      end

      always_comb begin
         rem_in = {cur_rem, cur_src[63:62]};
         trial  = {32'd0, cur_root, 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= cur_vld;
         end
         if (adv) begin
            src_ff[i+1]  <= {cur_src[61:0], 2'b00};
            side_ff[i+1] <= cur_side;
            if (rem_in >= trial) begin
               rem_ff[i+1]  <= 64'(rem_in - trial);
               root_ff[i+1] <= {cur_root[30:0], 1'b1};
            end else begin
               rem_ff[i+1]  <= rem_in[63:0];
               root_ff[i+1] <= {cur_root[30:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS];
   assign out_root  = root_ff[SQRT_STEPS];
   assign out_side  = side_ff[SQRT_STEPS];
endmodule
`default_nettype wire

// ===== src/v3n_div.sv =====
`default_nettype none
// Pipelined restoring divider: (mag << 30) / len, one quotient bit per stage.
// The quotient never exceeds 2^30 when mag <= len, as holds for every accepted
// vector, so only the low bits are kept at the end.
module v3n_div (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [31:0] in_mag,
   input  wire logic [31:0] in_len,
   output logic [31:0]      out_quo
);
   import v3n_pkg::*;

   logic [62:0] num_ff [1:DIV_STEPS];
   logic [32:0] rem_ff [1:DIV_STEPS];
   logic [31:0] len_ff [1:DIV_STEPS];
   logic [62:0] quo_ff [1:DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
      logic [62:0] cur_num;
      logic [32:0] cur_rem;
      logic [31:0] cur_len;
      logic [62:0] cur_quo;
      logic [33:0] shifted;

      // The first stage starts from the scaled magnitude with nothing decided.
      if (i == 0) begin : g_first
         assign cur_num = {1'b0, in_mag, 30'd0};
         assign cur_rem = '0;
         assign cur_len = in_len;
         assign cur_quo = '0;
      end else begin : g_next
         assign cur_num = num_ff[i];
         assign cur_rem = rem_ff[i];
         assign cur_len = len_ff[i];
         assign cur_quo = quo_ff[i];
      end

      always_comb begin
         shifted = {cur_rem, cur_num[62]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[i+1] <= {cur_num[61:0], 1'b0};
            len_ff[i+1] <= cur_len;
            if (shifted >= {2'b00, cur_len}) begin
               rem_ff[i+1] <= 33'(shifted - {2'b00, cur_len});
               quo_ff[i+1] <= {cur_quo[61:0], 1'b1};
            end else begin
               rem_ff[i+1] <= shifted[32:0];
               quo_ff[i+1] <= {cur_quo[61:0], 1'b0};
            end
         end
      end
   end

   assign out_quo = quo_ff[DIV_STEPS][31:0];
endmodule
`default_nettype wire

// ===== src/vector3_normalizer.sv =====
`default_nettype none
// Normalizes a signed Q16.16 3-D vector to signed Q2.30 components, one vector
// per cycle. The datapath is a fixed pipeline: one stage for the magnitudes,
// two for the squares and their sum, 32 square-root stages (one root bit each),
// one length check stage, 63 divider stages (one quotient bit each, three
// dividers side by side) and one sign/output stage, 100 register stages in all.
// When rsp_ready is low the whole pipeline holds; req_ready is low only while
// the output register is full and not taken.
// epsilon_len (address 0) must only be written while the block is empty.
module vector3_normalizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire v3n_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output v3n_pkg::rsp_type       rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [1:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import v3n_pkg::*;
   `include "vector3_normalizer_defines.svh"

   localparam int SideW = 3 * 32 + 3;

   logic        adv;
   logic [31:0] eps_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_EPSILON_LEN) ? eps_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == ADDR_EPSILON_LEN) begin
         eps_ff <= csr_pwdata;
      end
   end

   // The pipeline advances whenever the output stage is free or being taken.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Stage 1: magnitudes and signs.
   logic        s1_vld_ff;
   logic [31:0] s1_mag_ff [3];
   logic [2:0]  s1_neg_ff;
   logic [31:0] in_comp [3];
   assign in_comp[0] = req_data.in_x;
   assign in_comp[1] = req_data.in_y;
   assign in_comp[2] = req_data.in_z;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s1_neg_ff[k] <= in_comp[k][31];
            s1_mag_ff[k] <= in_comp[k][31] ? 32'(-in_comp[k]) : in_comp[k];
         end
      end
   end

   // Stage 2: squares. Stage 3: sum.
   logic        s2_vld_ff, s3_vld_ff;
   logic [63:0] s2_sq_ff [3];
   logic [63:0] s3_sum_ff;
   logic [SideW-1:0] s2_side_ff, s3_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s2_sq_ff[k] <= 64'(s1_mag_ff[k]) * 64'(s1_mag_ff[k]);
         end
         s2_side_ff <= {s1_neg_ff, s1_mag_ff[0], s1_mag_ff[1], s1_mag_ff[2]};
         s3_sum_ff  <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
         s3_side_ff <= s2_side_ff;
      end
   end

   // Square root of the sum of squares.
   logic             rt_vld;
   logic [31:0]      rt_len;
   logic [SideW-1:0] rt_side;
   v3n_sqrt #(.SideW(SideW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s3_vld_ff),
      .in_sum    (s3_sum_ff),
      .in_side   (s3_side_ff),
      .out_valid (rt_vld),
      .out_root  (rt_len),
      .out_side  (rt_side)
   );

   // Length check; a rejected vector divides by one to keep the divider sane.
   logic        s4_vld_ff;
   logic        s4_ok_ff;
   logic [31:0] s4_len_ff;
   logic [SideW-1:0] s4_side_ff;
   logic        len_ok;
   assign len_ok = (rt_len != 32'd0) && (rt_len > eps_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= rt_vld;
      end
      if (adv) begin
         s4_ok_ff   <= len_ok;
         s4_len_ff  <= len_ok ? rt_len : 32'd1;
         s4_side_ff <= rt_side;
      end
   end

   // Three dividers, with valid/ok/sign bits delayed alongside.
   logic [31:0] quo [3];
   for (genvar k = 0; k < 3; k++) begin : g_div
      v3n_div u_div (
         .clock   (clock),
         .adv     (adv),
         .in_mag  (s4_side_ff[32*(2-k) +: 32]),
         .in_len  (s4_len_ff),
         .out_quo (quo[k])
      );
   end

   logic [DIV_STEPS-1:0] dv_vld_ff;
   logic [3:0]           dv_side_ff [DIV_STEPS];
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else if (adv) begin
         dv_vld_ff <= {dv_vld_ff[DIV_STEPS-2:0], s4_vld_ff};
      end
      if (adv) begin
         dv_side_ff[0] <= {s4_ok_ff, s4_side_ff[SideW-1 -: 3]};
         for (int j = 1; j < DIV_STEPS; j++) begin
            dv_side_ff[j] <= dv_side_ff[j-1];
         end
      end
   end

   // Output register: apply signs, zero the result when rejected.
   logic        ok_d;
   logic [2:0]  neg_d;
   rsp_type     rsp_ff;
   logic        rsp_vld_ff;
   logic [31:0] res [3];
   assign ok_d  = dv_side_ff[DIV_STEPS-1][3];
   assign neg_d = dv_side_ff[DIV_STEPS-1][2:0];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res[k] = !ok_d ? 32'd0 : (neg_d[k] ? 32'(-quo[k]) : quo[k]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv_vld_ff[DIV_STEPS-1];
      end
      if (adv) begin
         rsp_ff.out_x <= res[0];
         rsp_ff.out_y <= res[1];
         rsp_ff.out_z <= res[2];
         rsp_ff.ok    <= ok_d;
      end
   end
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Checks.
   `V3N_ASSERT_IMP(a_not_ok_zero, clock, reset, rsp_valid && !rsp_data.ok,
      rsp_data.out_x == 0 && rsp_data.out_y == 0 && rsp_data.out_z == 0,
      "rejected vector gave nonzero result")
   `V3N_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "stalled result changed")
   `V3N_ASSERT_IMP(a_ok_nonzero_len, clock, reset, s4_vld_ff && s4_ok_ff,
      s4_len_ff > eps_ff, "accepted length not above epsilon")
endmodule
`default_nettype wire

// ===== tb/vector3_normalizer_test.sv =====
`default_nettype none
module vector3_normalizer_test;
   import v3n_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   vector3_normalizer uut (.*);

   // Clock with a period of 4 time units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bit [31:0] epsilon;
   req_type   vector_queue[$];
   rsp_type   unit_queue[$];
   int        error_count = 0;
   bit        calm = 1'b0;

   // Unsigned magnitude of a signed Q16.16 component.
   function automatic logic [31:0] abs32(logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // Floor square root of a 64-bit value, one result bit per iteration.
   function automatic logic [31:0] floor_sqrt(logic [63:0] s);
      logic [63:0] root;
      logic [63:0] probe;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         probe = root | (64'd1 << b);
         if (probe * probe <= s) root = probe;
      end
      return root[31:0];
   endfunction

   // Expected unit vector for one input vector.
   function automatic rsp_type normalize(req_type v);
      rsp_type     r;
      logic [31:0] m[3];
      logic [31:0] c[3];
      logic [63:0] sum;
      logic [31:0] len;
      logic [63:0] q;
      c[0] = v.in_x; c[1] = v.in_y; c[2] = v.in_z;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = abs32(c[i]);
         sum += 64'(m[i]) * 64'(m[i]);
      end
      len = floor_sqrt(sum);
      r = '0;
      if (len == 0 || len <= epsilon) return r;
      for (int i = 0; i < 3; i++) begin
         q = (64'(m[i]) << 30) / 64'(len);
         if (c[i][31]) q = ~q + 64'd1;
         c[i] = q[31:0];
      end
      r.out_x = c[0]; r.out_y = c[1]; r.out_z = c[2]; r.ok = 1'b1;
      return r;
   endfunction

   // Input transfers are seen at the rising edge and predicted there.
   bit sent = 1'b0;
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         unit_queue.push_back(normalize(req_data));
         sent <= 1'b1;
      end else begin
         sent <= 1'b0;
      end
   end

   // Driver: presents queued vectors, with random idle bursts.
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || sent) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (vector_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= vector_queue.pop_front();
               if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stalls in random bursts.
   int stall = 0;
   always @(negedge clock) begin
      if (stall > 0) begin
         stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      end
   end

   // Monitor: checks each result transfer against the oldest prediction.
   rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (unit_queue.size() == 0) begin
            $error("unexpected result out_x=%h", rsp_data.out_x);
            error_count++;
         end else begin
            want = unit_queue.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x expected %h actual %h", want.out_x, rsp_data.out_x);
               error_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y expected %h actual %h", want.out_y, rsp_data.out_y);
               error_count++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $error("out_z expected %h actual %h", want.out_z, rsp_data.out_z);
               error_count++;
            end
            if (rsp_data.ok !== want.ok) begin
               $error("ok expected %b actual %b", want.ok, rsp_data.ok);
               error_count++;
            end
         end
      end
   end

   // APB write of the length threshold.
   task automatic write_epsilon(logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_EPSILON_LEN; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      epsilon = value;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Wait until all queued vectors have gone through and results are back.
   task automatic drain();
      while (vector_queue.size() > 0 || req_valid || unit_queue.size() > 0)
         @(posedge clock);
      repeat (110) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_component();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 15) - 8;
         1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type v;
      v.in_x = x; v.in_y = y; v.in_z = z;
      return v;
   endfunction

   // Each phase runs under its own threshold, extremes included.
   initial begin
      logic [31:0] thresholds[6];
      thresholds = '{32'd0, 32'd1, 32'h0001_0000, 32'h0000_0100,
                     32'hffff_ffff, 32'h0010_0000};
      epsilon = 0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // Directed: zeros, unit axes, extremes, tiny vectors.
      vector_queue.push_back(vec(0, 0, 0));
      vector_queue.push_back(vec(32'h0001_0000, 0, 0));
      vector_queue.push_back(vec(0, 32'hffff_0000, 0));
      vector_queue.push_back(vec(0, 0, 32'h0001_0000));
      vector_queue.push_back(vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      vector_queue.push_back(vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      vector_queue.push_back(vec(32'h8000_0000, 32'h7fff_ffff, 0));
      vector_queue.push_back(vec(1, 0, 0));
      vector_queue.push_back(vec(32'hffff_ffff, 1, 32'hffff_ffff));
      vector_queue.push_back(vec(32'h8000_0000, 0, 0));
      vector_queue.push_back(vec(3, 4, 0));
      vector_queue.push_back(vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
      drain();
      foreach (thresholds[p]) begin
         write_epsilon(thresholds[p]);
         if (p == 5) calm = 1'b1;
         for (int i = 0; i < 290; i++)
            vector_queue.push_back(vec(rand_component(), rand_component(),
                                       rand_component()));
         drain();
      end
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
